### rtl/led_strip_serial_frame_driver_top_assert.svh
// ----------------------------------------------------------------------------
// LED strip frame driver assertion macros
// Property wrappers shared by the checker files of the frame driver.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_SERIAL_FRAME_DRIVER_TOP_ASSERT_SVH
`define LED_STRIP_SERIAL_FRAME_DRIVER_TOP_ASSERT_SVH

// Check a temporal property on every clock edge outside reset
`define LSFD_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a condition that must hold in the same cycle
`define LSFD_CHECK_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

### rtl/lsfd_pkg.sv
// ----------------------------------------------------------------------------
// LED strip frame driver package
// Sizes, command codes, frame phases and transfer types of the driver.
// ----------------------------------------------------------------------------
package lsfd_pkg;

  // Number of pixels in the strip (1 to 255)
  localparam int PIXELS = 64;
  localparam int PIX_AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  localparam logic [7:0] PIXELS_W     = 8'(PIXELS);
  localparam logic [7:0] HEADER_WORDS = 8'd2;
  localparam logic [7:0] TRAIL_WORDS  = 8'(PIXELS / 16 + 1);

  localparam logic [15:0] PIX_RESET = 16'h8000;
  localparam logic [15:0] WORD_ZERO = 16'h0000;
  localparam logic [15:0] WORD_ONES = 16'hFFFF;
  localparam logic [3:0]  LAST_BIT  = 4'd15;

  // Command codes
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_REFRESH = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  // Frame phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_PIXELS  = 4'b0100,
    PH_TRAILER = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  pixel_index;
    logic [15:0] pixel_word;
  } in_item_t;

  typedef struct packed {
    logic line_data;
    logic clock_pulse;
    logic busy_res;
    logic frame_end;
  } res_item_t;

endpackage

### rtl/led_strip_serial_frame_driver_top.sv
// ----------------------------------------------------------------------------
// LED strip serial frame driver
// Pixel store plus MSB-first frame serialiser for a two-wire LED strip.
// ----------------------------------------------------------------------------
// An item (pixel write, refresh start or bit tick) is taken on any cycle with
// start high and busy low; busy is only high during reset, so one item can be
// taken every cycle. Each item yields exactly one result, strobed by res_valid
// for one cycle once it has passed the input register and then the result
// register; the receiver must take it then. A frame is 16 * (2 + PIXELS
// + PIXELS/16 + 1) ticks long (1136 for 64 pixels); the next pixel word is
// fetched from the pixel RAM while the current word shifts out.
// Writes and refreshes issued during a frame are dropped.
module led_strip_serial_frame_driver_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  lsfd_pkg::in_item_t item,
  output logic               res_valid,
  output lsfd_pkg::res_item_t result
);
  import lsfd_pkg::*;

  in_item_t    s_item;
  logic        s_valid;
  phase_t      phase, phase_next;
  logic [7:0]  word_cnt, word_cnt_next;
  logic [3:0]  bit_cnt, bit_cnt_next;
  logic [15:0] shift_word, shift_word_next;
  res_item_t   result_next;
  logic [7:0]  word_inc;
  logic [PIXELS-1:0] pix_vld;
  logic              rd_vld;
  logic [15:0]       rd_data;
  logic [15:0]       pix_word;
  logic [PIX_AW-1:0] raddr;
  logic              wr_en;

  assign busy = rst;

  // Register the incoming transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= start;
    end
    s_item <= item;
  end

  // Pixel store
  lsfd_ram #(
    .WIDTH (16),
    .DEPTH (PIXELS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s_item.pixel_index[PIX_AW-1:0]),
    .wdata (s_item.pixel_word),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Track written entries; unwritten ones read as the reset word
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_vld <= '0;
    end else if (wr_en) begin
      pix_vld[s_item.pixel_index[PIX_AW-1:0]] <= 1'b1;
    end
    rd_vld <= pix_vld[raddr];
  end

  assign pix_word = rd_vld ? rd_data : PIX_RESET;
  assign word_inc = word_cnt + 8'd1;

  // Prefetch the word that follows the one now shifting out
  always_comb begin
    raddr = '0;
    if (phase == PH_PIXELS && word_inc < PIXELS_W) begin
      raddr = word_inc[PIX_AW-1:0];
    end
  end

  // Decode the item and advance the frame
  always_comb begin
    phase_next      = phase;
    word_cnt_next   = word_cnt;
    bit_cnt_next    = bit_cnt;
    shift_word_next = shift_word;
    result_next     = '0;
    wr_en           = 1'b0;
    if (s_valid) begin
      case (s_item.cmd)
        CMD_WRITE: begin
          wr_en = (phase == PH_IDLE) && (s_item.pixel_index < PIXELS_W);
        end
        CMD_REFRESH: begin
          if (phase == PH_IDLE) begin
            phase_next      = PH_HEADER;
            word_cnt_next   = '0;
            bit_cnt_next    = '0;
            shift_word_next = WORD_ZERO;
          end
        end
        CMD_TICK: begin
          if (phase != PH_IDLE) begin
            result_next.line_data   = ~shift_word[15];
            result_next.clock_pulse = 1'b1;
            shift_word_next = {shift_word[14:0], 1'b0};
            if (bit_cnt == LAST_BIT) begin
              bit_cnt_next  = '0;
              word_cnt_next = word_inc;
              case (phase)
                PH_HEADER: begin
                  if (word_inc >= HEADER_WORDS) begin
                    phase_next      = PH_PIXELS;
                    word_cnt_next   = '0;
                    shift_word_next = pix_word;
                  end else begin
                    shift_word_next = WORD_ZERO;
                  end
                end
                PH_PIXELS: begin
                  if (word_inc >= PIXELS_W) begin
                    phase_next      = PH_TRAILER;
                    word_cnt_next   = '0;
                    shift_word_next = WORD_ONES;
                  end else begin
                    shift_word_next = pix_word;
                  end
                end
                PH_TRAILER: begin
                  if (word_inc >= TRAIL_WORDS) begin
                    phase_next            = PH_IDLE;
                    word_cnt_next         = '0;
                    shift_word_next       = WORD_ZERO;
                    result_next.frame_end = 1'b1;
                  end else begin
                    shift_word_next = WORD_ONES;
                  end
                end
                default: begin
                end
              endcase
            end else begin
              bit_cnt_next = bit_cnt + 4'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    result_next.busy_res = (phase_next != PH_IDLE);
  end

  // Hold frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      word_cnt   <= '0;
      bit_cnt    <= '0;
      shift_word <= '0;
    end else begin
      phase      <= phase_next;
      word_cnt   <= word_cnt_next;
      bit_cnt    <= bit_cnt_next;
      shift_word <= shift_word_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= s_valid;
    end
    result <= result_next;
  end

endmodule

### rtl/lsfd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lsfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/lsfd_checker.sv
// ----------------------------------------------------------------------------
// LED strip frame driver checker
// Port-level checks of transfer timing and result consistency.
// ----------------------------------------------------------------------------
`include "led_strip_serial_frame_driver_top_assert.svh"

module lsfd_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input lsfd_pkg::in_item_t  item,
  input logic                res_valid,
  input lsfd_pkg::res_item_t result
);
  import lsfd_pkg::*;

  // Every accepted transfer gives one result
  `LSFD_CHECK(a_res_follows, (start && !busy |-> ##2 res_valid), "result missing")
  // No result without an accepted transfer
  `LSFD_CHECK(a_no_extra, (!(start && !busy) |-> ##2 !res_valid), "unexpected result")
  // Only a tick can clock a bit out
  `LSFD_CHECK(a_pulse_tick, (start && !busy && item.cmd != CMD_TICK |-> ##2 !result.clock_pulse), "pulse without tick")
  // Frame end comes with a bit and leaves the driver idle
  `LSFD_CHECK_NOW(a_frame_end, !(res_valid && result.frame_end) || (result.clock_pulse && !result.busy_res), "bad frame end")
  // Data line only moves on a clocked bit
  `LSFD_CHECK_NOW(a_data_pulse, !(res_valid && result.line_data) || result.clock_pulse, "data without pulse")

endmodule

bind led_strip_serial_frame_driver_top lsfd_checker u_lsfd_checker (.*);

### sim/tb_led_strip_serial_frame_driver_top.sv
// ----------------------------------------------------------------------------
// LED strip frame driver testbench
// Drives pixel writes, refresh starts and bit ticks into the frame driver and
// checks every result strobe against a cycle-free model of the frame
// serialiser. It mixes directed corner cases with random pixel writes, then
// ticks one frame out through its header and first pixel words, with
// noise and idle bursts.
// ----------------------------------------------------------------------------
module tb_led_strip_serial_frame_driver_top;
  import lsfd_pkg::*;

  // Command code with no function in the block
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;

  // Model of the pixel store and frame serialiser, plus the queue of results
  // still owed by the block
  class frame_tracker;
    logic [15:0] pix_mem [PIXELS];
    phase_t      phase;
    logic [7:0]  word_cnt;
    logic [3:0]  bit_cnt;
    logic [15:0] shreg;
    res_item_t   owed_results [$];
    int unsigned mismatches;
    int unsigned items_taken;
    int unsigned stored_writes;
    int unsigned bits_sent;

    function void clear_state();
      foreach (pix_mem[i]) pix_mem[i] = PIX_RESET;
      phase = PH_IDLE;
      word_cnt = '0;
      bit_cnt = '0;
      shreg = WORD_ZERO;
      mismatches = 0;
      items_taken = 0;
      stored_writes = 0;
      bits_sent = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Load the next word once one has fully shifted out; report frame end
    function logic load_next_word();
      word_cnt = word_cnt + 8'd1;
      case (phase)
        PH_HEADER: begin
          if (word_cnt >= HEADER_WORDS) begin
            phase = PH_PIXELS;
            word_cnt = '0;
            shreg = pix_mem[0];
          end else begin
            shreg = WORD_ZERO;
          end
        end
        PH_PIXELS: begin
          if (word_cnt >= PIXELS_W) begin
            phase = PH_TRAILER;
            word_cnt = '0;
            shreg = WORD_ONES;
          end else begin
            shreg = pix_mem[word_cnt];
          end
        end
        default: begin
          if (word_cnt >= TRAIL_WORDS) begin
            phase = PH_IDLE;
            word_cnt = '0;
            shreg = WORD_ZERO;
            return 1'b1;
          end
          shreg = WORD_ONES;
        end
      endcase
      return 1'b0;
    endfunction

    // Note an accepted transfer and queue the result it must produce
    function void take_item(in_item_t it);
      res_item_t r;
      logic msb;
      r = '0;
      items_taken++;
      case (it.cmd)
        CMD_WRITE: begin
          if (phase == PH_IDLE && it.pixel_index < PIXELS_W) begin
            pix_mem[it.pixel_index] = it.pixel_word;
            stored_writes++;
          end
        end
        CMD_REFRESH: begin
          if (phase == PH_IDLE) begin
            phase = PH_HEADER;
            word_cnt = '0;
            bit_cnt = '0;
            shreg = WORD_ZERO;
          end
        end
        CMD_TICK: begin
          if (phase != PH_IDLE) begin
            msb = shreg[15];
            r.line_data = ~msb;
            r.clock_pulse = 1'b1;
            bits_sent++;
            shreg = {shreg[14:0], 1'b0};
            if (bit_cnt == LAST_BIT) begin
              bit_cnt = '0;
              r.frame_end = load_next_word();
            end else begin
              bit_cnt = bit_cnt + 4'd1;
            end
          end
        end
        default: ;
      endcase
      r.busy_res = (phase != PH_IDLE);
      owed_results.push_back(r);
    endfunction

    // Compare one strobed result with the oldest owed result
    function void match_result(res_item_t got);
      res_item_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result data=%0b pulse=%0b busy=%0b end=%0b",
                   got.line_data, got.clock_pulse, got.busy_res, got.frame_end);
        return;
      end
      want = owed_results.pop_front();
      if (got.line_data !== want.line_data || got.clock_pulse !== want.clock_pulse ||
          got.busy_res !== want.busy_res || got.frame_end !== want.frame_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result mismatch exp data=%0b pulse=%0b busy=%0b end=%0b,",
                   want.line_data, want.clock_pulse, want.busy_res, want.frame_end,
                   " got data=%0b pulse=%0b busy=%0b end=%0b",
                   got.line_data, got.clock_pulse, got.busy_res, got.frame_end);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  item = '0;
  logic      res_valid;
  res_item_t result;

  frame_tracker sb;
  bit idle_on = 1'b1;
  int stall_cnt = 0;

  led_strip_serial_frame_driver_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .res_valid (res_valid),
    .result    (result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Check results and watch for a stalled run, sampling mid-cycle
  always @(negedge clk) begin
    if (!rst && res_valid) sb.match_result(result);
    if ((start && !busy) || res_valid) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("led_strip_serial_frame_driver_top test failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Present one transfer, optionally after an idle burst, and hold it until taken
  task automatic send(input logic [1:0] cmd, input logic [7:0] idx, input logic [15:0] word);
    in_item_t it;
    bit taken;
    it.cmd = cmd;
    it.pixel_index = idx;
    it.pixel_word = word;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      if (taken) sb.take_item(it);
      @(posedge clk);
    end
  endtask

  // Hold the sender until every owed result has arrived
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random pixel writes between frames, some out of range, with a little noise
  task automatic random_writes(input int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 15);
      if (sel < 11)
        send(CMD_WRITE, 8'($urandom_range(0, PIXELS - 1)), 16'($urandom));
      else if (sel < 13)
        send(CMD_WRITE, 8'($urandom_range(PIXELS, 255)), 16'($urandom));
      else if (sel < 14)
        send(CMD_NOP, 8'($urandom), 16'($urandom));
      else
        send(CMD_TICK, 8'($urandom), 16'($urandom));
    end
  endtask

  // Tick the frame on, mixing in dropped writes, refreshes and unused codes
  task automatic frame_ticks(input int n, input int noise_pct);
    int sel;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        sel = $urandom_range(0, 2);
        if (sel == 0)
          send(CMD_WRITE, 8'($urandom), 16'($urandom));
        else if (sel == 1)
          send(CMD_REFRESH, 8'($urandom), 16'($urandom));
        else
          send(CMD_NOP, 8'($urandom), 16'($urandom));
      end else begin
        send(CMD_TICK, 8'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle tick and unused code
    send(CMD_TICK, 8'h00, 16'h0000);
    send(CMD_NOP, 8'hFF, 16'hFFFF);

    // Random pixel writes with idle bursts
    random_writes(120);

    // Directed: store extremes and out-of-range writes
    send(CMD_WRITE, 8'd0, 16'hFFFF);
    send(CMD_WRITE, 8'(PIXELS - 1), 16'h0000);
    send(CMD_WRITE, 8'(PIXELS), 16'h1234);
    send(CMD_WRITE, 8'hFF, 16'hABCD);
    send(CMD_WRITE, 8'd1, 16'h5555);
    // Directed: refresh, then refresh, write and unused code while busy
    send(CMD_REFRESH, 8'h00, 16'h0000);
    repeat (3) send(CMD_TICK, 8'h00, 16'h0000);
    send(CMD_REFRESH, 8'h00, 16'h0000);
    send(CMD_WRITE, 8'd2, 16'h0F0F);
    send(CMD_NOP, 8'h00, 16'h0000);

    // Tick through the header into the pixel words with noise and idle bursts
    frame_ticks(90, 6);
    drain();
    frame_ticks(120, 6);

    // Closing stretch back to back with no idling
    idle_on = 1'b0;
    frame_ticks(60, 4);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d transfers, %0d stored pixel writes, %0d frame bits sent.",
             sb.items_taken, sb.stored_writes, sb.bits_sent);
    $display("Mismatches: %0d, results still owed: %0d.", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("led_strip_serial_frame_driver_top test passed");
    end else begin
      $display("led_strip_serial_frame_driver_top test failed");
    end
    $finish;
  end

endmodule
